FILE: sv/stbs_pkg.sv
// Package for the sorted key table with binary search.
// Holds sizes and the request and response item types; no dependencies.
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int INDEX_W     = 10;  // width of the entry_index and match_index fields
  localparam int CNT_W       = 11;  // width of the entry_count register
  localparam int KEY_W       = 32;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // signed bound, spans -1 .. TABLE_DEPTH
  typedef logic signed [CNT_W:0] bound_t;

  typedef struct packed {
    logic                    cmd;
    logic [INDEX_W-1:0]      entry_index;
    logic signed [KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
  } response_t;

endpackage

FILE: sv/sorted_table_binary_search.sv
// Sorted key table with binary search, top level.
// Depends on stbs_pkg for sizes and item types.
//
// Usage:
//   An item on request is accepted at a rising edge with start high and
//   busy low. A write item (cmd = write) stores key at entry_index and
//   gives no result; busy stays low, so items may follow back
//   to back. A search item raises busy and runs a binary search over the
//   first entry_count slots, one probe per cycle: the key table is a
//   synchronous RAM with one write and one read port, and each probe is
//   one read of it, the compare and next midpoint done in the cycle the
//   read data comes out.
//   Busy stays high while a search probes; done is registered and
//   pulses for one cycle after the last probe, or with no probe when
//   entry_count is 0. At 1024 entries a search takes at most 11 probes.
//   The response is valid only while done is high; the receiver cannot
//   stall, it must take the item in that cycle. A new item may be
//   accepted in the cycle done is high.
//   The user writes entry_count through cfg_we/cfg_data only while idle;
//   the block does not enforce it. Counts above the depth saturate to it.
//   Reset (rst, synchronous) clears entry_count, the state and done. The
//   table contents are not cleared; only written slots may be searched.
module sorted_table_binary_search
  import stbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  request_t         request,
  output logic             busy,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  output logic             done,
  output response_t        response
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_PROBE = 1'b1;

  logic [KEY_W-1:0] key_table [TABLE_DEPTH];
  logic [KEY_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;

  logic                    state, state_next;
  logic [CNT_W-1:0]        entry_count;
  logic [CNT_W-1:0]        count_sat;
  bound_t                  low, low_next;
  bound_t                  high, high_next;
  logic [ADDR_W-1:0]       mid, mid_next;
  logic signed [KEY_W-1:0] key_reg;

  logic             done_next;
  response_t        response_next;
  logic             accept;
  logic signed [KEY_W-1:0] probe;
  bound_t           mid_b;
  bound_t           cand_low, cand_high;
  logic signed [CNT_W+1:0] mid_sum;

  assign accept = start && !busy;
  assign busy   = (state == S_PROBE);
  assign probe  = $signed(rd_data);
  assign mid_b  = bound_t'({1'b0, mid});

  assign count_sat = (entry_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entry_count;

  // next bounds after a miss at mid
  assign cand_low  = (probe < key_reg) ? (mid_b + bound_t'(1)) : low;
  assign cand_high = (probe > key_reg) ? (mid_b - bound_t'(1)) : high;

  always_comb begin
    state_next    = state;
    low_next      = low;
    high_next     = high;
    mid_next      = mid;
    done_next     = 1'b0;
    response_next = '{found: 1'b0, match_index: '0};
    mid_sum       = '0;
    rd_addr       = mid;
    unique case (state)
      S_IDLE: begin
        if (accept && request.cmd == CMD_SEARCH) begin
          low_next  = '0;
          high_next = bound_t'({1'b0, count_sat}) - bound_t'(1);
          mid_sum   = {2'b00, count_sat} - (CNT_W+2)'(1);
          mid_next  = ADDR_W'(mid_sum >>> 1);
          rd_addr   = mid_next;
          if (count_sat == '0) begin
            done_next = 1'b1;  // empty table, nothing to probe
          end else begin
            state_next = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (probe == key_reg) begin
          done_next     = 1'b1;
          response_next = '{found: 1'b1, match_index: INDEX_W'(mid)};
          state_next    = S_IDLE;
        end else begin
          low_next  = cand_low;
          high_next = cand_high;
          mid_sum   = (CNT_W+2)'(cand_low) + (CNT_W+2)'(cand_high);
          mid_next  = ADDR_W'(mid_sum >>> 1);
          rd_addr   = mid_next;
          if (cand_low > cand_high) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // table RAM: one write port and one read port, registered read data
  always_ff @(posedge clk) begin
    if (accept && request.cmd == CMD_WRITE &&
        32'(request.entry_index) < 32'(TABLE_DEPTH)) begin
      key_table[ADDR_W'(request.entry_index)] <= request.key;
    end
    rd_data <= key_table[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_we) begin
        entry_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    low      <= low_next;
    high     <= high_next;
    mid      <= mid_next;
    response <= response_next;
    if (accept) begin
      key_reg <= request.key;
    end
  end

  // a result only follows a probe or an empty-table search
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_PROBE) ||
             ($past(accept) && $past(request.cmd) == CMD_SEARCH))
    else $error("done without a search in progress");

  // a miss reports index zero
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    (done && !response.found) |-> (response.match_index == '0))
    else $error("miss with nonzero match_index");

  // while probing the bounds have not crossed
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (low <= high && low >= 0))
    else $error("probe with crossed bounds");

  // a hit lies inside the searched entries
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    (done && response.found) |-> (CNT_W'(response.match_index) < count_sat))
    else $error("hit outside the valid entries");

endmodule
